@@ rtl/modexp_pkg.sv @@
package modexp_pkg;

  localparam int WORD_BITS_DEFAULT = 32;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PICK,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

endpackage

@@ rtl/modexp_step_unit.sv @@
// Shared modular step: result = (2*acc + addend) mod modulus,
// valid for acc < modulus and addend <= modulus.
module modexp_step_unit #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
  input  logic [WORD_BITS-1:0] acc,
  input  logic [WORD_BITS-1:0] addend,
  input  logic [WORD_BITS-1:0] modulus,
  output logic [WORD_BITS-1:0] result
);

  localparam int EXT_BITS = WORD_BITS + 3;

  logic [EXT_BITS-1:0] sum;
  logic [EXT_BITS-1:0] sub_one;
  logic [EXT_BITS-1:0] sub_two;

  // sum stays below three times the modulus, so one of the three candidates is in range
  assign sum     = {2'b00, acc, 1'b0} + {3'b000, addend};
  assign sub_one = sum - {3'b000, modulus};
  assign sub_two = sum - {2'b00, modulus, 1'b0};

  always_comb begin
    if (!sub_two[EXT_BITS-1]) begin
      result = sub_two[WORD_BITS-1:0];
    end else if (!sub_one[EXT_BITS-1]) begin
      result = sub_one[WORD_BITS-1:0];
    end else begin
      result = sum[WORD_BITS-1:0];
    end
  end

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation: power_result = message ^ exponent mod modulus.
// Exponent and modulus are set through the write port (cfg_we, cfg_index,
// cfg_data), by the user only while the block is idle; the block does not
// enforce it. Index REG_EXPONENT and REG_MODULUS, other indexes are ignored.
// Reset sets exponent to 0 and modulus to 1. A message transfers when
// msg_valid is high and msg_stall is low; the block stalls the input for the
// whole computation of one item. The exponent is scanned from its LSB. Every
// modular product is built MSB first, one multiplier bit per cycle, by one
// shared double-and-add-mod unit, which also reduces the message modulo the
// modulus at the start. Then, for each exponent bit up to its highest set
// one, the result is multiplied by the base if the bit is set and the base
// is squared; finally the output register is loaded. A zero exponent gives 1
// and a zero modulus with a nonzero exponent gives 0, without computation.
// The result waits in an output register until res_valid meets a low
// res_stall; a new message may transfer meanwhile, and the block holds its
// next result until the output register frees up.
module modular_exponentiation_unit #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                  cfg_data,
  input  logic                                  msg_valid,
  output logic                                  msg_stall,
  input  logic [WORD_BITS-1:0]                  message,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic [WORD_BITS-1:0]                  power_result
);

  localparam int CNT_BITS = $clog2(WORD_BITS);

  modexp_pkg::state_t state, state_next;

  logic [WORD_BITS-1:0] exponent, modulus;
  logic [WORD_BITS-1:0] exp_left, exp_left_next;
  logic [WORD_BITS-1:0] base, base_next;
  logic [WORD_BITS-1:0] res, res_next;
  logic [WORD_BITS-1:0] mul_a, mul_a_next;
  logic [WORD_BITS-1:0] mul_b, mul_b_next;
  logic [WORD_BITS-1:0] acc, acc_next;
  logic [CNT_BITS-1:0]  bit_cnt, bit_cnt_next;
  logic                 res_valid_next;
  logic [WORD_BITS-1:0] power_result_next;

  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS-1:0] step_out;
  logic [WORD_BITS-1:0] one_mod;

  assign msg_stall = (state != modexp_pkg::ST_IDLE);

  // reduction feeds message bits; products feed the multiplicand
  always_comb begin
    if (state == modexp_pkg::ST_REDUCE) begin
      addend = {{(WORD_BITS-1){1'b0}}, mul_b[WORD_BITS-1]};
    end else begin
      addend = mul_b[WORD_BITS-1] ? mul_a : '0;
    end
  end

  assign one_mod = (modulus == {{(WORD_BITS-1){1'b0}}, 1'b1}) ? '0 :
                   {{(WORD_BITS-1){1'b0}}, 1'b1};

  modexp_step_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_step (
    .acc    (acc),
    .addend (addend),
    .modulus(modulus),
    .result (step_out)
  );

  always_comb begin
    state_next        = state;
    exp_left_next     = exp_left;
    base_next         = base;
    res_next          = res;
    mul_a_next        = mul_a;
    mul_b_next        = mul_b;
    acc_next          = acc;
    bit_cnt_next      = bit_cnt;
    res_valid_next    = res_valid;
    power_result_next = power_result;

    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      modexp_pkg::ST_IDLE: begin
        if (msg_valid) begin
          if (exponent == '0) begin
            res_next   = {{(WORD_BITS-1){1'b0}}, 1'b1};
            state_next = modexp_pkg::ST_DONE;
          end else if (modulus == '0) begin
            res_next   = '0;
            state_next = modexp_pkg::ST_DONE;
          end else begin
            mul_b_next   = message;
            acc_next     = '0;
            bit_cnt_next = CNT_BITS'(WORD_BITS - 1);
            state_next   = modexp_pkg::ST_REDUCE;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        acc_next     = step_out;
        mul_b_next   = {mul_b[WORD_BITS-2:0], 1'b0};
        bit_cnt_next = bit_cnt - CNT_BITS'(1);
        if (bit_cnt == '0) begin
          base_next     = step_out;
          res_next      = one_mod;
          exp_left_next = exponent;
          state_next    = modexp_pkg::ST_PICK;
        end
      end
      modexp_pkg::ST_PICK: begin
        acc_next     = '0;
        bit_cnt_next = CNT_BITS'(WORD_BITS - 1);
        mul_a_next   = base;
        if (exp_left == '0) begin
          state_next = modexp_pkg::ST_DONE;
        end else if (exp_left[0]) begin
          mul_b_next = res;
          state_next = modexp_pkg::ST_MUL;
        end else begin
          mul_b_next = base;
          state_next = modexp_pkg::ST_SQR;
        end
      end
      modexp_pkg::ST_MUL: begin
        acc_next     = step_out;
        mul_b_next   = {mul_b[WORD_BITS-2:0], 1'b0};
        bit_cnt_next = bit_cnt - CNT_BITS'(1);
        if (bit_cnt == '0) begin
          res_next     = step_out;
          acc_next     = '0;
          bit_cnt_next = CNT_BITS'(WORD_BITS - 1);
          mul_a_next   = base;
          mul_b_next   = base;
          state_next   = modexp_pkg::ST_SQR;
        end
      end
      modexp_pkg::ST_SQR: begin
        acc_next     = step_out;
        mul_b_next   = {mul_b[WORD_BITS-2:0], 1'b0};
        bit_cnt_next = bit_cnt - CNT_BITS'(1);
        if (bit_cnt == '0) begin
          base_next     = step_out;
          exp_left_next = {1'b0, exp_left[WORD_BITS-1:1]};
          state_next    = modexp_pkg::ST_PICK;
        end
      end
      modexp_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!res_valid || !res_stall) begin
          power_result_next = res;
          res_valid_next    = 1'b1;
          state_next        = modexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= modexp_pkg::ST_IDLE;
      res_valid <= 1'b0;
      exponent  <= '0;
      modulus   <= {{(WORD_BITS-1){1'b0}}, 1'b1};
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        if (cfg_index == modexp_pkg::REG_EXPONENT) begin
          exponent <= cfg_data;
        end else if (cfg_index == modexp_pkg::REG_MODULUS) begin
          modulus <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    exp_left     <= exp_left_next;
    base         <= base_next;
    res          <= res_next;
    mul_a        <= mul_a_next;
    mul_b        <= mul_b_next;
    acc          <= acc_next;
    bit_cnt      <= bit_cnt_next;
    power_result <= power_result_next;
  end

endmodule
